/* rtl/lpf_pkg.sv */
// ----------------------------------------------------------------------------
// lpf_pkg: shared types and constants for the link packet framer
// Word width, register indexes, reset values, timing classes and the
// configuration bundle that is passed from the register block to the framer.
// ----------------------------------------------------------------------------
package lpf_pkg;

    localparam int WORD_W               = 16;
    localparam int WORDS_PER_PACKET_DEF = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_HS_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_WORD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_WORD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_PRESENT = 3'd4;

    // Handshake modes
    localparam logic [1:0] HS_DISABLED = 2'd0;
    localparam logic [1:0] HS_ENABLED  = 2'd1;
    localparam logic [1:0] HS_CONNECT  = 2'd2;

    // Reset values
    localparam logic [WORD_W-1:0] MASTER_WORD_RST  = 16'h8FFF;
    localparam logic [WORD_W-1:0] SLAVE_WORD_RST   = 16'hB9A0;
    localparam logic [WORD_W-1:0] DISABLE_WORD_RST = 16'h0000;
    localparam logic [WORD_W-1:0] WORD_ZERO        = 16'h0000;

    // Gap before the next transfer
    typedef enum logic [1:0] {
        TC_HANDSHAKE = 2'd0,
        TC_BYTES     = 2'd1,
        TC_BETWEEN   = 2'd2
    } timing_class_t;

    typedef struct packed {
        logic [1:0]        handshake_mode;
        logic [WORD_W-1:0] master_word;
        logic [WORD_W-1:0] slave_word;
        logic [WORD_W-1:0] disable_word;
        logic              source_present;
    } cfg_t;

endpackage

/* rtl/link_packet_framer.sv */
// ----------------------------------------------------------------------------
// link_packet_framer: framing layer for a 16-bit word link
// Tracks handshake, check and command phases, sums command pairs and picks
// the next word to send after every finished transfer.
// ----------------------------------------------------------------------------
// Use:
//   Present one finished transfer per request on the input channel
//   (in_valid/in_ready with rx_word, tx_word, next_cmd_word). One result
//   request per input appears on the output channel (out_valid/out_ready
//   with next_tx, frame_done, timing_class, check_sum).
//   Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
//   cfg_ready is always high. Write registers only while the block is idle.
//   A result is registered and valid in the cycle after its input is taken.
//   Throughput: one transfer per cycle; the phase update and the 16-bit
//   three-input add sit between the phase registers and the result register.
//   A stalled receiver holds the result register; in_ready then follows
//   out_ready, so a new transfer is taken in the same cycle the waiting
//   result leaves.
//   Reset: handshake phase, sum loaded with the slave word reset value,
//   slot count cleared, registers at their reset values, no result pending.
//   Captured command pairs and the last handshake words are not observable
//   at the ports and are therefore not stored.
// ----------------------------------------------------------------------------
module link_packet_framer
    import lpf_pkg::*;
#(
    parameter int WORDS_PER_PACKET = WORDS_PER_PACKET_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_W-1:0]    rx_word,
    input  logic [WORD_W-1:0]    tx_word,
    input  logic [WORD_W-1:0]    next_cmd_word,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    next_tx,
    output logic                 frame_done,
    output logic [1:0]           timing_class,
    output logic [WORD_W-1:0]    check_sum
);

    localparam int CNT_W = $clog2(WORDS_PER_PACKET);
    localparam logic [CNT_W:0] LAST_SLOT   = (CNT_W+1)'(WORDS_PER_PACKET);
    localparam logic [CNT_W:0] BEFORE_LAST = (CNT_W+1)'(WORDS_PER_PACKET - 1);

    typedef enum logic [1:0] {
        PH_HANDSHAKE = 2'd0,
        PH_CHECK     = 2'd1,
        PH_COMMAND   = 2'd2
    } phase_t;

    cfg_t cfg;

    phase_t            phase_reg,   phase_next;
    logic [WORD_W-1:0] sum_reg,     sum_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    timing_class_t     timing_reg,  timing_next;
    logic [CNT_W:0]    count_inc;
    logic              done;
    logic [WORD_W-1:0] hs_word;
    logic [WORD_W-1:0] tx_sel;

    logic              out_valid_reg;
    logic [WORD_W-1:0] next_tx_reg;
    logic              complete_reg;
    timing_class_t     class_reg;
    logic [WORD_W-1:0] check_sum_reg;
    logic              in_fire;

    lpf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Take a new request whenever the result slot is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Handshake word for the current mode; the unused mode falls back to disable
    always_comb
    begin
        case (cfg.handshake_mode)
            HS_ENABLED: hs_word = cfg.slave_word;
            HS_CONNECT: hs_word = cfg.master_word;
            default:    hs_word = cfg.disable_word;
        endcase
    end

    // Phase update for one transfer
    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        timing_next = timing_reg;
        done        = 1'b0;
        count_inc   = {1'b0, count_reg} + (CNT_W+1)'(1);
        unique case (phase_reg)
            PH_CHECK:
            begin
                phase_next = PH_COMMAND;
                sum_next   = WORD_ZERO;
                count_next = '0;
            end
            PH_COMMAND:
            begin
                sum_next   = WORD_W'(sum_reg + rx_word + tx_word);
                count_next = count_inc[CNT_W-1:0];
                if (count_inc == BEFORE_LAST)
                begin
                    timing_next = TC_BETWEEN;
                end
                if (count_inc == LAST_SLOT)
                begin
                    count_next  = '0;
                    phase_next  = PH_CHECK;
                    timing_next = TC_BYTES;
                    done        = 1'b1;
                end
            end
            default:
            begin
                phase_next  = PH_HANDSHAKE;
                timing_next = TC_HANDSHAKE;
                if (rx_word == cfg.master_word || tx_word == cfg.master_word)
                begin
                    phase_next  = PH_CHECK;
                    timing_next = TC_BYTES;
                end
            end
        endcase
    end

    // Pick the next word to send from the updated phase
    always_comb
    begin
        case (phase_next)
            PH_CHECK:   tx_sel = sum_next;
            PH_COMMAND: tx_sel = cfg.source_present ? next_cmd_word : WORD_ZERO;
            default:    tx_sel = hs_word;
        endcase
    end

    // Hold phase state; advance on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HANDSHAKE;
            sum_reg    <= SLAVE_WORD_RST;
            count_reg  <= '0;
            timing_reg <= TC_HANDSHAKE;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            timing_reg <= timing_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; load only with a new request
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            next_tx_reg   <= tx_sel;
            complete_reg  <= done;
            class_reg     <= timing_next;
            check_sum_reg <= sum_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_tx      = next_tx_reg;
    assign frame_done   = complete_reg;
    assign timing_class = class_reg;
    assign check_sum    = check_sum_reg;

    // A completed packet always hands back to the check phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && done) |=> (phase_reg == PH_CHECK && count_reg == '0))
    else $error("packet completion did not return to check phase");

    // Leaving check clears the sum before the first command pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_CHECK) |=> (sum_reg == WORD_ZERO
            && out_valid_reg && check_sum_reg == WORD_ZERO))
    else $error("sum not cleared on entry to command phase");

    // Slots are counted only inside the command phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (phase_reg == PH_COMMAND))
    else $error("slot count set outside command phase");

    // A completion result always carries the command-bytes class
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && complete_reg) |-> (class_reg == TC_BYTES))
    else $error("completion result with wrong timing class");

    // A stalled result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(check_sum_reg) && out_valid_reg))
    else $error("pending result lost under stall");

endmodule

/* rtl/lpf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lpf_cfg_regs: configuration register file
// Takes write requests on the configuration channel and holds the handshake
// words, handshake mode and source flag. Unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lpf_cfg_regs
    import lpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Always able to take a write request
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode and store write requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.handshake_mode <= HS_DISABLED;
            cfg_reg.master_word    <= MASTER_WORD_RST;
            cfg_reg.slave_word     <= SLAVE_WORD_RST;
            cfg_reg.disable_word   <= DISABLE_WORD_RST;
            cfg_reg.source_present <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HS_MODE:     cfg_reg.handshake_mode <= cfg_data[1:0];
                REG_MASTER_WORD: cfg_reg.master_word    <= cfg_data;
                REG_SLAVE_WORD:  cfg_reg.slave_word     <= cfg_data;
                REG_DISABLE:     cfg_reg.disable_word   <= cfg_data;
                REG_SRC_PRESENT: cfg_reg.source_present <= cfg_data[0];
                default:         ;
            endcase
        end
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for link_packet_framer
// A table of directed requests and register writes takes the framer through
// every handshake mode, the exit to the check phase and one full packet.
// Random command traffic follows, with register rewrites between bursts.
// Every result is compared field by field with a model of the framer that
// this bench keeps. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import lpf_pkg::*;

    localparam int PAIRS        = WORDS_PER_PACKET_DEF;
    localparam int RANDOM_XFERS = 1250;
    localparam int IDLE_LIMIT   = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int PLAN_ROWS    = 28;

    // No register sits behind this index, so writes to it must be dropped.
    // Transfer rows in the plan also carry it as their unused index.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    // Mode code with no meaning of its own; it sends the disable word
    localparam logic [1:0] HS_UNUSED = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        LINK_HANDSHAKE,
        LINK_CHECK,
        LINK_COMMAND
    } link_phase_t;

    typedef enum logic {
        ROW_XFER,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        word_t         next_tx;
        logic          frame_done;
        timing_class_t timing;
        word_t         check_sum;
    } frame_result_t;

    // Register rows carry their write data in rx
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        word_t                rx;
        word_t                tx;
        word_t                cmd;
        logic                 typed;
        frame_result_t        want;
    } plan_row_t;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    word_t                cfg_data        = '0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    word_t                rx_word         = '0;
    word_t                tx_word         = '0;
    word_t                next_cmd_word   = '0;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    word_t                next_tx;
    logic                 frame_done;
    logic [1:0]           timing_class;
    word_t                check_sum;

    // Register copies, at their reset values
    logic [1:0]    shadow_mode    = HS_DISABLED;
    word_t         shadow_master  = MASTER_WORD_RST;
    word_t         shadow_slave   = SLAVE_WORD_RST;
    word_t         shadow_disable = DISABLE_WORD_RST;
    logic          shadow_source  = 1'b0;

    // Framer state as the model tracks it
    link_phase_t   fr_phase  = LINK_HANDSHAKE;
    word_t         fr_sum    = SLAVE_WORD_RST;
    logic [3:0]    fr_slot   = '0;
    timing_class_t fr_timing = TC_HANDSHAKE;

    frame_result_t expected_q [$];
    int            faults       = 0;
    int            quiet_cycles = 0;
    int unsigned   hold_left    = 0;
    logic          send_quiet   = 1'b0;
    logic          recv_quiet   = 1'b0;

    link_packet_framer #(
        .WORDS_PER_PACKET (PAIRS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_word         (rx_word),
        .tx_word         (tx_word),
        .next_cmd_word   (next_cmd_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .next_tx         (next_tx),
        .frame_done      (frame_done),
        .timing_class    (timing_class),
        .check_sum       (check_sum)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mirror a register write; unknown indexes change nothing
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
        case (idx)
            REG_HS_MODE:     shadow_mode    = data[1:0];
            REG_MASTER_WORD: shadow_master  = data;
            REG_SLAVE_WORD:  shadow_slave   = data;
            REG_DISABLE:     shadow_disable = data;
            REG_SRC_PRESENT: shadow_source  = data[0];
            default:         ;
        endcase
    endfunction

    // Advance the framer by one finished transfer and give its result
    function automatic frame_result_t frame_step(input word_t rx, input word_t tx,
                                                 input word_t cmd);
        frame_result_t r;
        r.frame_done = 1'b0;
        case (fr_phase)
            LINK_CHECK:
            begin
                fr_phase = LINK_COMMAND;
                fr_sum   = '0;
                fr_slot  = '0;
            end
            LINK_COMMAND:
            begin
                if (fr_slot < PAIRS)
                begin
                    fr_sum  = fr_sum + rx + tx;
                    fr_slot = fr_slot + 1'b1;
                end
                // next to last pair: gap widens to between commands
                if (fr_slot == PAIRS - 1)
                    fr_timing = TC_BETWEEN;
                if (fr_slot >= PAIRS)
                begin
                    fr_slot      = '0;
                    fr_phase     = LINK_CHECK;
                    fr_timing    = TC_BYTES;
                    r.frame_done = 1'b1;
                end
            end
            default:
            begin
                fr_timing = TC_HANDSHAKE;
                if (rx == shadow_master || tx == shadow_master)
                begin
                    fr_phase  = LINK_CHECK;
                    fr_timing = TC_BYTES;
                end
            end
        endcase

        // pick the next word from the phase after the update
        case (fr_phase)
            LINK_CHECK:   r.next_tx = fr_sum;
            LINK_COMMAND: r.next_tx = shadow_source ? cmd : WORD_ZERO;
            default:
            begin
                case (shadow_mode)
                    HS_ENABLED: r.next_tx = shadow_slave;
                    HS_CONNECT: r.next_tx = shadow_master;
                    default:    r.next_tx = shadow_disable;
                endcase
            end
        endcase
        r.timing    = fr_timing;
        r.check_sum = fr_sum;
        return r;
    endfunction

    // Random word, leaning on both extremes
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return word_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one transfer request and book its expected result on acceptance
    task automatic send_transfer(input word_t rx, input word_t tx, input word_t cmd,
                                 input logic typed, input frame_result_t want);
        int unsigned   gap;
        frame_result_t model;
        gap = send_quiet ? 0 : $urandom_range(0, 4);
        cfg_valid <= 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        rx_word       <= rx;
        tx_word       <= tx;
        next_cmd_word <= cmd;
        do @(posedge clk); while (!(in_valid && in_ready));
        model = frame_step(rx, tx, cmd);
        expected_q.push_back(typed ? want : model);
    endtask

    // Write one register; valid stays up so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        apply_reg(idx, data);
    endtask

    // Hold off new requests until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    // Check each result taken and draw the stall before the next one
    always @(posedge clk)
    begin : check_results
        frame_result_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: next_tx %h check_sum %h", next_tx, check_sum);
                    faults++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (next_tx !== e.next_tx)
                    begin
                        $error("next_tx: expected %h, got %h", e.next_tx, next_tx);
                        faults++;
                    end
                    if (frame_done !== e.frame_done)
                    begin
                        $error("frame_done: expected %b, got %b",
                               e.frame_done, frame_done);
                        faults++;
                    end
                    if (timing_class !== e.timing)
                    begin
                        $error("timing_class: expected %0d, got %0d", e.timing, timing_class);
                        faults++;
                    end
                    if (check_sum !== e.check_sum)
                    begin
                        $error("check_sum: expected %h, got %h", e.check_sum, check_sum);
                        faults++;
                    end
                end
                hold_left = recv_quiet ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = !recv_quiet;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
            end
            out_ready <= (hold_left == 0);
        end
    end

    // Drop the run if no channel moves a request for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t   plan [PLAN_ROWS];
        int unsigned until_regs;

        plan = '{
            // handshake phase at reset settings: disable word goes out
            '{ROW_XFER, REG_SPARE, 16'h0000, 16'h0000, 16'hFFFF, 1'b1,
              '{16'h0000, 1'b0, TC_HANDSHAKE, SLAVE_WORD_RST}},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
              '{16'h0000, 1'b0, TC_HANDSHAKE, SLAVE_WORD_RST}},
            '{ROW_REG, REG_HS_MODE, 16'(HS_ENABLED), 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'h1234, 16'h8FFE, 16'h5A5A, 1'b1,
              '{SLAVE_WORD_RST, 1'b0, TC_HANDSHAKE, SLAVE_WORD_RST}},
            '{ROW_REG, REG_HS_MODE, 16'(HS_CONNECT), 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'h7FFF, 16'h8000, 16'hA5A5, 1'b1,
              '{MASTER_WORD_RST, 1'b0, TC_HANDSHAKE, SLAVE_WORD_RST}},
            // unused mode falls back to the disable word
            '{ROW_REG, REG_HS_MODE, 16'(HS_UNUSED), 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_REG, REG_DISABLE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'h0001, 16'hFFFE, 16'h0001, 1'b1,
              '{16'hFFFF, 1'b0, TC_HANDSHAKE, SLAVE_WORD_RST}},
            '{ROW_REG, REG_SPARE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_REG, REG_SRC_PRESENT, 16'h0001, 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_REG, REG_MASTER_WORD, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_REG, REG_HS_MODE, 16'(HS_DISABLED), 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b1,
              '{16'hFFFF, 1'b0, TC_HANDSHAKE, SLAVE_WORD_RST}},
            '{ROW_REG, REG_MASTER_WORD, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, '0},
            // a new slave word must leave the running sum alone
            '{ROW_REG, REG_SLAVE_WORD, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_REG, REG_HS_MODE, 16'(HS_ENABLED), 16'h0000, 16'h0000, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'h0000, 16'hFFFE, 16'h0000, 1'b1,
              '{16'h0000, 1'b0, TC_HANDSHAKE, SLAVE_WORD_RST}},
            // sent word matches master: on to check with the old sum
            '{ROW_XFER, REG_SPARE, 16'h0000, 16'hFFFF, 16'h1111, 1'b1,
              '{SLAVE_WORD_RST, 1'b0, TC_BYTES, SLAVE_WORD_RST}},
            '{ROW_XFER, REG_SPARE, 16'h5555, 16'hAAAA, 16'hABCD, 1'b1,
              '{16'hABCD, 1'b0, TC_BYTES, 16'h0000}},
            // eight all-ones pairs; the eighth closes the packet
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'h00FF, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'hFF00, 1'b0, '0},
            '{ROW_XFER, REG_SPARE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
              '{16'hFFF0, 1'b1, TC_BYTES, 16'hFFF0}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].rx);
            end
            else
            begin
                send_transfer(plan[i].rx, plan[i].tx, plan[i].cmd, plan[i].typed,
                              plan[i].want);
            end
        end

        // random command traffic, rewriting registers between bursts
        until_regs = $urandom_range(60, 140);
        for (int n = 0; n < RANDOM_XFERS; n++)
        begin
            if (until_regs == 0)
            begin
                drain();
                repeat ($urandom_range(1, 3))
                    write_reg(CFG_IDX_W'($urandom_range(0, 7)), pick_word());
                until_regs = $urandom_range(60, 140);
            end
            until_regs--;
            if ($urandom_range(0, 39) == 0)
                send_quiet = !send_quiet;
            send_transfer(pick_word(), pick_word(), pick_word(), 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/lpf_pkg.sv
rtl/lpf_cfg_regs.sv
rtl/link_packet_framer.sv
tb/testbench.sv
